// File: rtl/core/brf_pkg.sv
// brf_pkg: shared types, command codes and size constants for the byte ring fifo
// no dependencies; imported by every module under rtl/core
package brf_pkg;

    localparam int BRF_DEPTH = 4096;   // default byte slots in the store
    localparam int DATA_W    = 8;
    localparam int AMT_W     = 13;     // width of counts, offsets and capacity
    localparam int CMD_W     = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADV_WR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ADV_RD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data_in;
        logic [AMT_W-1:0]  amount_or_offset;
    } cmd_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [AMT_W-1:0]  amount_done;
        logic [AMT_W-1:0]  fill_level;
    } result_t;

endpackage

// File: rtl/core/byte_ring_fifo.sv
// byte_ring_fifo: top level of the circular byte store with configurable capacity
// depends on brf_pkg, brf_ctrl and brf_mem
//
// The block takes one command item per clock and never stalls: busy is always low, so
// an item is taken at every edge where start is high. Each item gives exactly one
// result through the item register, then the result register and store read
// register, shown for one cycle with result_valid; the receiver cannot hold it off
// and must take it in that cycle. Commands are push, pop, peek at an offset past the
// read position, advance write, advance read (counts clipped to free space or fill
// level) and clear. Pointers and fill count are updated in the cycle after the item
// register, so the next item sees them at once. Writing the capacity register clamps
// the value to 1..DEPTH and empties the store; write it only while no item is in
// flight. The byte store is not cleared: a byte skipped by advance write and never
// written reads back as an undefined value.
module byte_ring_fifo
    import brf_pkg::*;
#(
    parameter int DEPTH = BRF_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  cmd_item_t        cmd_item,
    // result channel
    output logic             result_valid,
    output result_t          result,
    // capacity register
    input  logic             cfg_we,
    input  logic [AMT_W-1:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic              accept;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              res_from_mem;
    logic [AMT_W-1:0]  res_amount;
    logic [AMT_W-1:0]  res_fill;

    // fully pipelined, one item per clock
    assign busy   = 1'b0;
    assign accept = start && !busy;

    brf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (cmd_item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .res_valid    (result_valid),
        .res_from_mem (res_from_mem),
        .res_amount   (res_amount),
        .res_fill     (res_fill)
    );

    brf_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // data byte only for a pop or peek that found a byte, zero otherwise
    always_comb
    begin
        result.data_out    = res_from_mem ? mem_rdata : '0;
        result.amount_done = res_amount;
        result.fill_level  = res_fill;
    end

    // every taken item gives its result, after the item and result registers
    a_item_to_result : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 result_valid)
        else $error("taken item produced no result");

    // no result without an item taken before it, through the item register
    a_result_from_item : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
        else $error("result without a taken item");

    // a data byte only comes with a successful pop or peek
    a_data_needs_done : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.amount_done == '0)) |-> (result.data_out == '0))
        else $error("data byte on a result that moved nothing");

    // fill level never exceeds the store size
    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (int'(result.fill_level) <= DEPTH))
        else $error("fill level beyond store size");

endmodule

// File: rtl/core/brf_mem.sv
// brf_mem: byte store, one write port and one read port with registered read data
// depends on brf_pkg for the data width
module brf_mem
    import brf_pkg::*;
#(
    parameter int DEPTH = BRF_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/brf_ctrl.sv
// brf_ctrl: item register, pointer and count update, store access and result register
// depends on brf_pkg for the item type, the widths and the command codes
module brf_ctrl
    import brf_pkg::*;
#(
    parameter int DEPTH = BRF_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  cmd_item_t                item,
    input  logic                     cfg_we,
    input  logic [AMT_W-1:0]         cfg_wdata,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [DATA_W-1:0]        mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    output logic                     res_valid,
    output logic                     res_from_mem,
    output logic [AMT_W-1:0]         res_amount,
    output logic [AMT_W-1:0]         res_fill
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int W      = ((CNT_W > AMT_W) ? CNT_W : AMT_W) + 1;

    // pos < cap and n <= cap, so one conditional subtract wraps
    function automatic logic [W-1:0] wrap_add(input logic [W-1:0] pos,
                                              input logic [W-1:0] n,
                                              input logic [W-1:0] cap);
        logic [W-1:0] s;
        s = pos + n;
        if (s >= cap)
        begin
            s = s - cap;
        end
        return s;
    endfunction

    // item stage
    logic              item_valid_reg;
    cmd_item_t         item_reg;

    // architectural state
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [ADDR_W-1:0] wpos_reg, wpos_next;
    logic [ADDR_W-1:0] rpos_reg, rpos_next;

    // result stage
    logic              res_valid_reg;
    logic              res_from_mem_reg, res_from_mem_next;
    logic [AMT_W-1:0]  res_amount_reg, res_amount_next;
    logic [AMT_W-1:0]  res_fill_reg;

    logic [W-1:0]      cap_w, held_w, wpos_w, rpos_w, amt_w, free_w, n_w, done_w;
    logic [W-1:0]      held_upd_w, wpos_upd_w, rpos_upd_w, cfg_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign cap_w  = W'(cap_reg);
    assign held_w = W'(held_reg);
    assign wpos_w = W'(wpos_reg);
    assign rpos_w = W'(rpos_reg);
    assign amt_w  = W'(item_reg.amount_or_offset);
    assign free_w = cap_w - held_w;
    assign cfg_w  = W'(cfg_wdata);

    always_comb
    begin
        held_upd_w        = held_w;
        wpos_upd_w        = wpos_w;
        rpos_upd_w        = rpos_w;
        done_w            = '0;
        n_w               = '0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_raddr         = rpos_reg;
        res_from_mem_next = 1'b0;
        if (item_valid_reg)
        begin
            case (item_reg.cmd)
                CMD_PUSH:
                begin
                    if (held_w < cap_w)
                    begin
                        mem_we     = 1'b1;
                        wpos_upd_w = wrap_add(wpos_w, W'(1), cap_w);
                        held_upd_w = held_w + W'(1);
                        done_w     = W'(1);
                    end
                end
                CMD_POP:
                begin
                    if (held_w != '0)
                    begin
                        mem_re            = 1'b1;
                        rpos_upd_w        = wrap_add(rpos_w, W'(1), cap_w);
                        held_upd_w        = held_w - W'(1);
                        done_w            = W'(1);
                        res_from_mem_next = 1'b1;
                    end
                end
                CMD_PEEK:
                begin
                    if (amt_w < held_w)
                    begin
                        mem_re            = 1'b1;
                        mem_raddr         = ADDR_W'(wrap_add(rpos_w, amt_w, cap_w));
                        done_w            = W'(1);
                        res_from_mem_next = 1'b1;
                    end
                end
                CMD_ADV_WR:
                begin
                    n_w        = (amt_w < free_w) ? amt_w : free_w;
                    wpos_upd_w = wrap_add(wpos_w, n_w, cap_w);
                    held_upd_w = held_w + n_w;
                    done_w     = n_w;
                end
                CMD_ADV_RD:
                begin
                    n_w        = (amt_w < held_w) ? amt_w : held_w;
                    rpos_upd_w = wrap_add(rpos_w, n_w, cap_w);
                    held_upd_w = held_w - n_w;
                    done_w     = n_w;
                end
                CMD_CLEAR:
                begin
                    held_upd_w = '0;
                    wpos_upd_w = '0;
                    rpos_upd_w = '0;
                end
                default:
                begin
                end
            endcase
        end
        res_amount_next = AMT_W'(done_w);
    end

    assign mem_waddr = wpos_reg;
    assign mem_wdata = item_reg.data_in;

    // capacity write clamps to 1..DEPTH and empties the store
    always_comb
    begin
        cap_next  = cap_reg;
        held_next = CNT_W'(held_upd_w);
        wpos_next = ADDR_W'(wpos_upd_w);
        rpos_next = ADDR_W'(rpos_upd_w);
        if (cfg_we)
        begin
            if (cfg_w == '0)
            begin
                cap_next = CNT_W'(1);
            end
            else if (cfg_w > W'(DEPTH))
            begin
                cap_next = CNT_W'(DEPTH);
            end
            else
            begin
                cap_next = CNT_W'(cfg_w);
            end
            held_next = '0;
            wpos_next = '0;
            rpos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CNT_W'(DEPTH);
            held_reg      <= '0;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            held_reg      <= held_next;
            wpos_reg      <= wpos_next;
            rpos_reg      <= rpos_next;
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            res_from_mem_reg <= res_from_mem_next;
            res_amount_reg   <= res_amount_next;
            res_fill_reg     <= AMT_W'(held_upd_w);
        end
    end

    assign res_valid    = res_valid_reg;
    assign res_from_mem = res_from_mem_reg;
    assign res_amount   = res_amount_reg;
    assign res_fill     = res_fill_reg;

endmodule

// File: dv/tb_byte_ring_fifo.sv
// tb_byte_ring_fifo: self-checking testbench for the byte ring fifo, with a
// scoreboard class that mirrors the store and plain tasks that drive commands
// depends on brf_pkg and byte_ring_fifo
module tb_byte_ring_fifo;
    import brf_pkg::*;

    localparam int DEPTH = BRF_DEPTH;
    // codes 6 and 7 are not commands; the block must treat them as no-ops
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
    localparam logic [AMT_W-1:0] AMT_MAX   = '1;
    // spare wait after the results are in, to catch any stray result
    localparam int DRAIN_CYCLES   = 6;
    localparam int IDLE_LIMIT     = 1000;
    localparam int ITEMS_PER_RUN  = 125;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_item_t        cmd_item;
    logic             result_valid;
    result_t          result;
    logic             cfg_we;
    logic [AMT_W-1:0] cfg_wdata;

    byte_ring_fifo #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd_item     (cmd_item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // mirror of the ring: store contents, pointers, fill count and capacity,
    // plus the queue of results still owed by the block
    class ring_mirror;
        logic [DATA_W-1:0] mem [DEPTH];
        bit                written [DEPTH];   // slot has held a pushed byte
        int unsigned       wr_pos;
        int unsigned       rd_pos;
        int unsigned       held;
        logic [AMT_W-1:0]  cap_reg;
        result_t           due_results [$];
        int unsigned       errors;

        function new();
            foreach (written[i]) written[i] = 1'b0;
            wr_pos  = 0;
            rd_pos  = 0;
            held    = 0;
            cap_reg = AMT_W'(DEPTH);
            errors  = 0;
        endfunction

        // capacity as the block uses it: clamped to 1..DEPTH
        function int unsigned eff_cap();
            if (cap_reg < 1) return 1;
            if (cap_reg > DEPTH) return DEPTH;
            return cap_reg;
        endfunction

        function int unsigned wrap_add(int unsigned pos, int unsigned n, int unsigned c);
            int unsigned s;
            s = pos + n;
            if (s >= c) s -= c;
            return s;
        endfunction

        // a capacity write also empties the ring; store contents stay
        function void set_capacity(logic [AMT_W-1:0] v);
            cap_reg = v;
            wr_pos  = 0;
            rd_pos  = 0;
            held    = 0;
        endfunction

        // true when the item would return a byte that was never written
        function bit reads_unwritten(cmd_item_t it);
            if (it.cmd == CMD_POP)
                return (held > 0) && !written[rd_pos];
            if (it.cmd == CMD_PEEK && it.amount_or_offset < held)
                return !written[wrap_add(rd_pos, it.amount_or_offset, eff_cap())];
            return 1'b0;
        endfunction

        // apply one accepted item and queue the result it must produce
        function void take_item(cmd_item_t it);
            result_t     want;
            int unsigned c;
            int unsigned n;
            int unsigned amt;
            c    = eff_cap();
            amt  = it.amount_or_offset;
            want = '0;
            case (it.cmd)
                CMD_PUSH:
                    if (held < c) begin
                        mem[wr_pos]      = it.data_in;
                        written[wr_pos]  = 1'b1;
                        wr_pos           = wrap_add(wr_pos, 1, c);
                        held++;
                        want.amount_done = 1;
                    end
                CMD_POP:
                    if (held > 0) begin
                        want.data_out    = mem[rd_pos];
                        rd_pos           = wrap_add(rd_pos, 1, c);
                        held--;
                        want.amount_done = 1;
                    end
                CMD_PEEK:
                    if (amt < held) begin
                        want.data_out    = mem[wrap_add(rd_pos, amt, c)];
                        want.amount_done = 1;
                    end
                CMD_ADV_WR: begin
                    n = c - held;
                    if (amt < n) n = amt;
                    wr_pos           = wrap_add(wr_pos, n, c);
                    held            += n;
                    want.amount_done = AMT_W'(n);
                end
                CMD_ADV_RD: begin
                    n = held;
                    if (amt < n) n = amt;
                    rd_pos           = wrap_add(rd_pos, n, c);
                    held            -= n;
                    want.amount_done = AMT_W'(n);
                end
                CMD_CLEAR: begin
                    wr_pos = 0;
                    rd_pos = 0;
                    held   = 0;
                end
                default: ;
            endcase
            want.fill_level = AMT_W'(held);
            due_results.push_back(want);
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h/%0d/%0d",
                         $time, got.data_out, got.amount_done, got.fill_level);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.data_out !== want.data_out) begin
                $display("%0t: data_out expected %h actual %h",
                         $time, want.data_out, got.data_out);
                errors++;
            end
            if (got.amount_done !== want.amount_done) begin
                $display("%0t: amount_done expected %0d actual %0d",
                         $time, want.amount_done, got.amount_done);
                errors++;
            end
            if (got.fill_level !== want.fill_level) begin
                $display("%0t: fill_level expected %0d actual %0d",
                         $time, want.fill_level, got.fill_level);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction
    endclass

    ring_mirror  ring;
    int unsigned idle_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // build one command item
    function automatic cmd_item_t mk(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d,
                                     logic [AMT_W-1:0] a);
        cmd_item_t it;
        it.cmd              = c;
        it.data_in          = d;
        it.amount_or_offset = a;
        return it;
    endfunction

    // idle cycles before the next item: mostly none, some short, a few long
    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // counts: mostly small, some up to the capacity, some over the full field
    function automatic logic [AMT_W-1:0] pick_amount(int unsigned c);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return AMT_W'($urandom_range(0, 8));
        if (r < 70) return AMT_W'($urandom_range(0, c));
        if (r < 85) return AMT_W'($urandom_range(0, AMT_MAX));
        case ($urandom_range(0, 3))
            0: return 0;
            1: return AMT_W'(c);
            2: return AMT_W'(c - 1);
            default: return AMT_MAX;
        endcase
    endfunction

    // random item that never reads a slot that was skipped and never written
    function automatic cmd_item_t random_item();
        cmd_item_t   it;
        int unsigned r;
        int unsigned c;
        c  = ring.eff_cap();
        r  = $urandom_range(0, 99);
        it = mk(CMD_PUSH, DATA_W'($urandom_range(0, 255)), pick_amount(c));
        if (r < 30)      it.cmd = CMD_PUSH;
        else if (r < 52) it.cmd = CMD_POP;
        else if (r < 67) it.cmd = CMD_PEEK;
        else if (r < 78) it.cmd = CMD_ADV_WR;
        else if (r < 89) it.cmd = CMD_ADV_RD;
        else if (r < 93) it.cmd = CMD_CLEAR;
        else if (r < 97) it.cmd = CMD_RSVD6;
        else             it.cmd = CMD_RSVD7;
        // peeks mostly land inside the held bytes
        if (it.cmd == CMD_PEEK && ring.held > 0 && $urandom_range(0, 9) < 7)
            it.amount_or_offset = AMT_W'($urandom_range(0, ring.held - 1));
        if (ring.reads_unwritten(it)) begin
            if (it.cmd == CMD_POP)
                it = mk(CMD_ADV_RD, it.data_in, 1);   // step over the skipped slot
            else
                it.amount_or_offset = AMT_W'(ring.held);   // peek just past the end
        end
        return it;
    endfunction

    // present one item after an optional gap and wait until it is taken
    task automatic send_item(cmd_item_t it, int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd_item <= it;
        do @(posedge clk); while (busy !== 1'b0);
        ring.take_item(it);
    endtask

    // wait until the block is idle, then write the capacity register
    task automatic write_capacity(logic [AMT_W-1:0] v);
        start <= 1'b0;
        while (ring.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        ring.set_capacity(v);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_run(logic [AMT_W-1:0] cap_value, int unsigned count, bit burst);
        write_capacity(cap_value);
        repeat (count) send_item(random_item(), pick_gap(burst));
    endtask

    // results are sampled at the edge that ends their cycle
    always @(posedge clk) begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
            ring.match_result(result);
    end

    // watchdog: too many cycles without any item or result moving
    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || result_valid === 1'b1)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, ring.pending());
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        ring        = new();
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd_item    <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset capacity: empty pop and peek, extreme bytes,
        // peek in and out of range, clipped advances, full push, no-op codes
        send_item(mk(CMD_POP,    8'h00, 0),       pick_gap(0));
        send_item(mk(CMD_PEEK,   8'h00, 0),       pick_gap(0));
        send_item(mk(CMD_PUSH,   8'h00, 0),       pick_gap(0));
        send_item(mk(CMD_PUSH,   8'hFF, AMT_MAX), pick_gap(0));
        send_item(mk(CMD_PEEK,   8'hFF, 0),       pick_gap(0));
        send_item(mk(CMD_PEEK,   8'h00, 1),       pick_gap(0));
        send_item(mk(CMD_PEEK,   8'h00, 2),       pick_gap(0));
        send_item(mk(CMD_PEEK,   8'h00, AMT_MAX), pick_gap(0));
        send_item(mk(CMD_POP,    8'h00, 0),       pick_gap(0));
        send_item(mk(CMD_ADV_WR, 8'h00, AMT_MAX), pick_gap(0));   // clips to free space
        send_item(mk(CMD_PUSH,   8'h3C, 0),       pick_gap(0));   // ring full
        send_item(mk(CMD_ADV_RD, 8'h00, 0),       pick_gap(0));
        send_item(mk(CMD_POP,    8'h00, 0),       pick_gap(0));
        send_item(mk(CMD_ADV_RD, 8'h00, AMT_MAX), pick_gap(0));   // clips to fill level
        send_item(mk(CMD_RSVD6,  8'hFF, AMT_MAX), pick_gap(0));
        send_item(mk(CMD_RSVD7,  8'hFF, AMT_MAX), pick_gap(0));
        send_item(mk(CMD_PUSH,   8'hA5, 0),       pick_gap(0));
        send_item(mk(CMD_CLEAR,  8'hFF, AMT_MAX), pick_gap(0));

        // capacity zero acts as one: wrap on every byte
        write_capacity(0);
        send_item(mk(CMD_PUSH,   8'h5A, 0), pick_gap(0));
        send_item(mk(CMD_PUSH,   8'h11, 0), pick_gap(0));   // full at one byte
        send_item(mk(CMD_PEEK,   8'h00, 0), pick_gap(0));
        send_item(mk(CMD_PEEK,   8'h00, 1), pick_gap(0));
        send_item(mk(CMD_POP,    8'h00, 0), pick_gap(0));
        send_item(mk(CMD_ADV_WR, 8'h00, 1), pick_gap(0));
        send_item(mk(CMD_ADV_RD, 8'h00, 3), pick_gap(0));

        // random runs over a spread of capacities, extremes included
        random_run(1,                                ITEMS_PER_RUN, 0);
        random_run(2,                                ITEMS_PER_RUN, 1);
        random_run(3,                                ITEMS_PER_RUN, 0);
        random_run(7,                                ITEMS_PER_RUN, 0);
        random_run(16,                               ITEMS_PER_RUN, 1);
        random_run(AMT_W'($urandom_range(1, 64)),     ITEMS_PER_RUN, 0);
        random_run(AMT_W'($urandom_range(65, DEPTH)), ITEMS_PER_RUN, 0);
        random_run(AMT_W'(DEPTH),                    ITEMS_PER_RUN, 1);
        random_run(AMT_MAX,                          ITEMS_PER_RUN, 0);
        random_run(AMT_W'($urandom_range(DEPTH + 1, AMT_MAX)), ITEMS_PER_RUN, 0);
        random_run(0,                                ITEMS_PER_RUN, 1);
        random_run(AMT_W'($urandom_range(0, AMT_MAX)), ITEMS_PER_RUN, 0);

        // drain the pipe, then wait on to catch any stray result
        start <= 1'b0;
        while (ring.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ring.errors == 0 && ring.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
